@@ sv/cdda_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdda_pkg
// Types, codes and calendar helpers shared by the date arithmetic block.
// ----------------------------------------------------------------------------
package cdda_pkg;

  // Operation codes of the func field
  localparam logic [1:0] FUNC_ADD  = 2'd0;
  localparam logic [1:0] FUNC_SUB  = 2'd1;
  localparam logic [1:0] FUNC_DIFF = 2'd2;

  localparam int unsigned MonthsPerYear = 12;
  localparam int unsigned LeapCycle     = 400;
  localparam int unsigned YearMax       = 9999;

  typedef struct packed {
    logic [1:0]  func;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [15:0] delta_days;
    logic [11:0] delta_months;
    logic [13:0] delta_years;
    logic [4:0]  second_day;
    logic [3:0]  second_month;
    logic [13:0] second_year;
  } req_t;

  typedef struct packed {
    logic [4:0]  result_day;
    logic [3:0]  result_month;
    logic [13:0] result_year;
    logic [4:0]  span_days;
    logic [3:0]  span_months;
    logic [13:0] span_years;
    logic        out_of_range;
  } res_t;

  // Working date; r holds the year modulo 400 once normalized
  typedef struct packed {
    logic signed [17:0] d;
    logic signed [13:0] m;
    logic signed [16:0] y;
    logic signed [16:0] r;
  } date_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_R400,
    DP_FOLD,
    DP_ADDD,
    DP_NORM,
    DP_SYNC,
    DP_STEP,
    DP_TAKE
  } dp_op_e;

  typedef enum logic [1:0] {
    PH_YEAR,
    PH_MONTH,
    PH_DAY
  } phase_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_R400,
    S_FOLD,
    S_ADDD,
    S_NORM,
    S_SYNC,
    S_STEP,
    S_CMP,
    S_DONE
  } state_e;

  typedef struct packed {
    dp_op_e op;
    phase_e phase;
    logic   sub;
  } dp_cmd_t;

  typedef struct packed {
    logic r_ok;
    logic fold_done;
    logic norm_done;
    logic le;
  } dp_sts_t;

  // Leap test on a year residue modulo 400
  function automatic logic is_leap(input logic [8:0] r);
    logic cent;
    cent = (r == 9'd0) || (r == 9'd100) || (r == 9'd200) || (r == 9'd300);
    return ((r[1:0] == 2'b00) && !cent) || (r == 9'd0);
  endfunction

  // Days in a month; months outside 1..12 count as 31 days
  function automatic logic [4:0] month_len(input logic signed [13:0] m, input logic leap);
    logic [4:0] n;
    n = 5'd31;
    if (m >= 14'sd1 && m <= 14'sd12) begin
      case (m[3:0])
        4'd2:                      n = leap ? 5'd29 : 5'd28;
        4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
        default:                   n = 5'd31;
      endcase
    end
    return n;
  endfunction

  function automatic logic signed [16:0] r_inc(input logic signed [16:0] r);
    return (r == 17'(LeapCycle - 1)) ? 17'sd0 : r + 17'sd1;
  endfunction

  function automatic logic signed [16:0] r_dec(input logic signed [16:0] r);
    return (r == 17'sd0) ? 17'(LeapCycle - 1) : r - 17'sd1;
  endfunction

endpackage

@@ sv/cdda_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdda_dp
// Date datapath: working date, lower and upper date, span counters.
// ----------------------------------------------------------------------------
module cdda_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cdda_pkg::req_t   req_i,
  input  cdda_pkg::dp_cmd_t cmd_i,
  output cdda_pkg::dp_sts_t sts_o,
  output cdda_pkg::res_t   res_o
);
  import cdda_pkg::*;

  date_t       w_q, w_d, lo_q, lo_d, hi_q, hi_d;
  logic [1:0]  func_q, func_d;
  logic [15:0] dd_q, dd_d;
  logic        bad_q, bad_d;
  logic [13:0] ny_q, ny_d;
  logic [3:0]  nm_q, nm_d;
  logic [4:0]  nd_q, nd_d;

  date_t       a_dt, b_dt, base;
  logic        a_lt_b;
  logic [4:0]  len_cur, len_prev;
  logic signed [13:0] m_prev;
  logic signed [16:0] y_prev, r_prev;
  logic signed [16:0] hy;
  logic signed [13:0] hm;
  logic signed [17:0] hd;

  // Input dates as working dates
  always_comb begin
    a_dt   = '{d: 18'(req_i.day), m: 14'(req_i.month), y: 17'(req_i.year),
               r: 17'(req_i.year)};
    b_dt   = '{d: 18'(req_i.second_day), m: 14'(req_i.second_month),
               y: 17'(req_i.second_year), r: 17'(req_i.second_year)};
    a_lt_b = (req_i.year != req_i.second_year) ? (req_i.year < req_i.second_year) :
             (req_i.month != req_i.second_month) ? (req_i.month < req_i.second_month) :
             (req_i.day < req_i.second_day);
  end

  // Month lengths for the forward and backward day walk
  always_comb begin
    len_cur = month_len(w_q.m, is_leap(w_q.r[8:0]));
    m_prev  = w_q.m - 14'sd1;
    y_prev  = w_q.y;
    r_prev  = w_q.r;
    if (m_prev < 14'sd1) begin
      m_prev = m_prev + 14'(MonthsPerYear);
      y_prev = w_q.y - 17'sd1;
      r_prev = r_dec(w_q.r);
    end
    len_prev = month_len(m_prev, is_leap(r_prev[8:0]));
  end

  // Status
  always_comb begin
    hy = hi_q.y;
    hm = hi_q.m;
    hd = hi_q.d;
    sts_o.r_ok      = (w_q.r >= 17'sd0) && (w_q.r < 17'(LeapCycle));
    sts_o.fold_done = cmd_i.sub ? (w_q.m >= 14'sd1) : (w_q.m <= 14'(MonthsPerYear));
    sts_o.norm_done = cmd_i.sub ? (w_q.d >= 18'sd1) : (w_q.d <= 18'(len_cur));
    sts_o.le        = (w_q.y != hy) ? (w_q.y < hy) :
                      (w_q.m != hm) ? (w_q.m < hm) : (w_q.d <= hd);
  end

  // Next state of the datapath
  always_comb begin
    w_d = w_q; lo_d = lo_q; hi_d = hi_q; func_d = func_q; dd_d = dd_q;
    bad_d = bad_q; ny_d = ny_q; nm_d = nm_q; nd_d = nd_q;
    base = lo_q;
    case (cmd_i.op)
      DP_LOAD: begin
        func_d = req_i.func;
        dd_d   = req_i.delta_days;
        ny_d = '0; nm_d = '0; nd_d = '0;
        bad_d = (req_i.year == 14'd0) || (req_i.year > 14'(YearMax)) ||
                (req_i.second_year == 14'd0) || (req_i.second_year > 14'(YearMax));
        if (req_i.func == FUNC_DIFF) begin
          w_d  = a_lt_b ? a_dt : b_dt;
          hi_d = a_lt_b ? b_dt : a_dt;
        end else begin
          w_d = a_dt;
          if (req_i.func == FUNC_SUB) begin
            w_d.y = a_dt.y - 17'(req_i.delta_years);
            w_d.m = a_dt.m - 14'(req_i.delta_months);
          end else begin
            w_d.y = a_dt.y + 17'(req_i.delta_years);
            w_d.m = a_dt.m + 14'(req_i.delta_months);
          end
          w_d.r = w_d.y;
        end
      end
      // one step toward 0 <= r < 400
      DP_R400: begin
        if (w_q.r < 17'sd0) w_d.r = w_q.r + 17'(LeapCycle);
        else                w_d.r = w_q.r - 17'(LeapCycle);
      end
      // move one year of months into or out of the year
      DP_FOLD: begin
        if (cmd_i.sub) begin
          w_d.m = w_q.m + 14'(MonthsPerYear);
          w_d.y = w_q.y - 17'sd1;
          w_d.r = r_dec(w_q.r);
        end else begin
          w_d.m = w_q.m - 14'(MonthsPerYear);
          w_d.y = w_q.y + 17'sd1;
          w_d.r = r_inc(w_q.r);
        end
      end
      DP_ADDD: begin
        if (cmd_i.sub) w_d.d = w_q.d - 18'(dd_q);
        else           w_d.d = w_q.d + 18'(dd_q);
      end
      // one month of the day walk
      DP_NORM: begin
        if (cmd_i.sub) begin
          w_d.m = m_prev;
          w_d.y = y_prev;
          w_d.r = r_prev;
          w_d.d = w_q.d + 18'(len_prev);
        end else begin
          w_d.d = w_q.d - 18'(len_cur);
          w_d.m = w_q.m + 14'sd1;
          if (w_q.m + 14'sd1 > 14'(MonthsPerYear)) begin
            w_d.m = w_q.m + 14'sd1 - 14'(MonthsPerYear);
            w_d.y = w_q.y + 17'sd1;
            w_d.r = r_inc(w_q.r);
          end
        end
      end
      DP_SYNC: lo_d = w_q;
      // candidate: lower date plus one unit of the phase
      DP_STEP: begin
        case (cmd_i.phase)
          PH_YEAR: begin
            base.y = lo_q.y + 17'sd1;
            base.r = r_inc(lo_q.r);
          end
          PH_MONTH: base.m = lo_q.m + 14'sd1;
          default:  base.d = lo_q.d + 18'sd1;
        endcase
        w_d = base;
      end
      DP_TAKE: begin
        lo_d = w_q;
        case (cmd_i.phase)
          PH_YEAR:  if (ny_q != '1) ny_d = ny_q + 14'd1;
          PH_MONTH: if (nm_q != '1) nm_d = nm_q + 4'd1;
          default:  if (nd_q != '1) nd_d = nd_q + 5'd1;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      func_q <= '0;
    end else begin
      func_q <= func_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q <= w_d; lo_q <= lo_d; hi_q <= hi_d; dd_q <= dd_d; bad_q <= bad_d;
    ny_q <= ny_d; nm_q <= nm_d; nd_q <= nd_d;
  end

  // Result word
  always_comb begin
    res_o = '0;
    if (func_q == FUNC_ADD || func_q == FUNC_SUB) begin
      res_o.result_day   = w_q.d[4:0];
      res_o.result_month = w_q.m[3:0];
      res_o.result_year  = w_q.y[13:0];
      res_o.out_of_range = (w_q.y < 17'sd1) || (w_q.y > 17'(YearMax));
    end else if (func_q == FUNC_DIFF) begin
      res_o.span_days    = nd_q;
      res_o.span_months  = nm_q;
      res_o.span_years   = ny_q;
      res_o.out_of_range = bad_q;
    end
  end

endmodule

@@ sv/cdda_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdda_ctrl
// Sequencer: walks the datapath through fold, day walk and span steps.
// ----------------------------------------------------------------------------
module cdda_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [1:0]        func_i,
  input  cdda_pkg::dp_sts_t sts_i,
  output cdda_pkg::dp_cmd_t cmd_o,
  output logic              busy_o,
  output logic              done_o
);
  import cdda_pkg::*;

  state_e     state_q, state_d;
  phase_e     phase_q, phase_d;
  logic [1:0] func_q, func_d;
  logic       diff;

  assign diff = (func_q == FUNC_DIFF);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_YEAR;
      func_q  <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      func_q  <= func_d;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    func_d    = func_q;
    cmd_o.op    = DP_NOP;
    cmd_o.phase = phase_q;
    cmd_o.sub   = (func_q == FUNC_SUB);
    busy_o    = (state_q != S_IDLE);
    done_o    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          func_d   = func_i;
          phase_d  = PH_YEAR;
          cmd_o.op = DP_LOAD;
          state_d  = (func_i == FUNC_ADD || func_i == FUNC_SUB || func_i == FUNC_DIFF)
                     ? S_R400 : S_DONE;
        end
      end
      S_R400: begin
        if (sts_i.r_ok) state_d = diff ? S_SYNC : S_FOLD;
        else            cmd_o.op = DP_R400;
      end
      S_FOLD: begin
        if (sts_i.fold_done) state_d = diff ? S_NORM : S_ADDD;
        else                 cmd_o.op = DP_FOLD;
      end
      S_ADDD: begin
        cmd_o.op = DP_ADDD;
        state_d  = S_NORM;
      end
      S_NORM: begin
        if (sts_i.norm_done) state_d = diff ? S_CMP : S_DONE;
        else                 cmd_o.op = DP_NORM;
      end
      S_SYNC: begin
        cmd_o.op = DP_SYNC;
        state_d  = S_STEP;
      end
      S_STEP: begin
        cmd_o.op = DP_STEP;
        state_d  = S_FOLD;
      end
      // keep the step if it does not pass the later date
      S_CMP: begin
        state_d = S_STEP;
        if (sts_i.le) begin
          cmd_o.op = DP_TAKE;
        end else begin
          case (phase_q)
            PH_YEAR:  phase_d = PH_MONTH;
            PH_MONTH: phase_d = PH_DAY;
            default:  state_d = S_DONE;
          endcase
        end
      end
      S_DONE: begin
        done_o  = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

@@ sv/calendar_date_delta_arithmetic.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_date_delta_arithmetic
// Gregorian date add, subtract and difference, one request at a time.
// ----------------------------------------------------------------------------
// A request word is taken when start is high and busy is low; the result word
// shows on res_o for the one cycle that done_o is high, and busy drops after
// it. The sequencer works step by step: it reduces the year modulo 400 in
// steps of 400, folds one year at a time out of the month count, and walks
// the day delta one month at a time. A difference runs step, fold, day
// walk and compare for each whole year, month and day counted. An unused
// func code answers with zeros.
module calendar_date_delta_arithmetic (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  cdda_pkg::req_t   req_i,
  output logic             done_o,
  output cdda_pkg::res_t   res_o
);
  import cdda_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    accept;

  assign accept = start && !busy;

  cdda_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .func_i  (req_i.func),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  cdda_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .res_o  (res_o)
  );

  // Checks
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("result strobe while idle");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy) else $error("not busy after accepted word");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o && !busy) else $error("result strobe longer than one cycle");

endmodule
